/* src/mavg_pkg.sv */
// Shared widths and constants for the moving average filter.
`timescale 1ns / 1ps

package mavg_pkg;

  // Deepest window the sample ring holds
  localparam int MAX_WINDOW = 32;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W      = $clog2(MAX_WINDOW) + 1;

  // Sample and accumulator widths
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  // Window length after reset
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

endpackage

/* src/moving_average_filter.sv */
// Boxcar moving average filter with a ring buffer memory and serial divider.
`timescale 1ns / 1ps

// Moving average over a stream of signed Q15 samples, one result item per
// input item. The last samples sit in a 32-entry single-port-write ring
// memory with a registered read; a running sum is updated by one
// read-modify-write per item, and the average is formed by a restoring
// divider that retires one quotient bit per cycle. An item during warm-up
// (raw sample passed through, warming_up set) skips the divider; an averaged
// item passes through it, which sets the rate; one item is in work at a time.
// The next item is accepted while a finished result still waits on the
// output. A write to the window length (clamped to 1..32) restarts the
// history, as does new_signal on an item; write it only while idle.
module moving_average_filter
  import mavg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration: window length
  input  logic                cfg_we,
  input  logic [WIN_W-1:0]    cfg_data,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
  input  logic                s_tuser,   // [0] new_signal
  // output stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] filtered
  output logic                m_tuser    // [0] warming_up
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [WIN_W-1:0]     window_length;
  logic [WIN_W-1:0]     samples_seen;
  logic [PTR_W-1:0]     ring_pointer;
  sum_t                 running_sum;

  // per-item registers
  sample_t              cur_sample;
  logic                 use_oldest;
  logic                 warm;

  // ring memory
  sample_t              sample_ring [MAX_WINDOW];
  sample_t              ring_rd;

  // divider
  logic [SUM_W-1:0]     dvd;
  logic [WIN_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 neg;
  sample_t              result;

  // output register
  sample_t              out_data;
  logic                 out_warm;
  logic                 out_valid;

  logic                 accept;
  logic [WIN_W-1:0]     seen_eff;
  logic [WIN_W-1:0]     count;
  logic [PTR_W-1:0]     old_addr;
  logic [WIN_W-1:0]     cfg_clamped;
  sum_t                 sum_upd;
  sample_t              oldest;
  logic [WIN_W:0]       trial;
  logic                 q_bit;
  logic [SAMPLE_W-1:0]  quot;
  logic                 out_free;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !out_valid || m_tready;

  // history seen by this item, after an optional restart
  assign seen_eff = s_tuser ? '0 : samples_seen;
  assign count    = seen_eff + WIN_W'(1);
  assign old_addr = ring_pointer - window_length[PTR_W-1:0];

  // clamp of a written window length
  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = WIN_W'(1);
    end else if (cfg_data > WIN_W'(MAX_WINDOW)) begin
      cfg_clamped = WIN_W'(MAX_WINDOW);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  // running sum update once the oldest sample is back from the ring
  assign oldest  = use_oldest ? ring_rd : '0;
  assign sum_upd = running_sum - SUM_W'(oldest) + SUM_W'(cur_sample);

  // one restoring divide step
  assign trial = {rem, dvd[SUM_W-1]};
  assign q_bit = (trial >= {1'b0, window_length});
  assign quot  = dvd[SAMPLE_W-1:0];

  // ring memory: read first, write at the current pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rd                   <= sample_ring[old_addr];
      sample_ring[ring_pointer] <= sample_t'(s_tdata);
    end
  end

  // control and history state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WINDOW_RESET;
      samples_seen  <= '0;
      ring_pointer  <= '0;
      running_sum   <= '0;
    end else begin
      if (cfg_we) begin
        window_length <= cfg_clamped;
        samples_seen  <= '0;
        running_sum   <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              running_sum <= '0;
            end
            samples_seen <= (count > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : count;
            ring_pointer <= ring_pointer + PTR_W'(1);
            state        <= S_READ;
          end
        end
        S_READ: begin
          running_sum <= sum_upd;
          state       <= warm ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item payload and divider datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cur_sample <= sample_t'(s_tdata);
          use_oldest <= (seen_eff >= window_length);
          warm       <= (count < window_length);
        end
      end
      S_READ: begin
        neg     <= sum_upd[SUM_W-1];
        dvd     <= sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
        rem     <= '0;
        div_cnt <= DIV_CNT_W'(SUM_W - 1);
        result  <= cur_sample;
      end
      S_DIV: begin
        rem     <= q_bit ? WIN_W'(trial - {1'b0, window_length}) : trial[WIN_W-1:0];
        dvd     <= {dvd[SUM_W-2:0], q_bit};
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      S_DONE: begin
        if (!warm) begin
          result <= neg ? sample_t'(-quot) : sample_t'(quot);
        end
      end
      default: begin
      end
    endcase
  end

  // output register, loaded as the item completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_warm <= warm;
      if (warm) begin
        out_data <= result;
      end else begin
        out_data <= neg ? sample_t'(-quot) : sample_t'(quot);
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_warm;

endmodule

/* verif/tb_moving_average_filter.sv */
// Self-checking testbench for the moving average filter stream block.
`timescale 1ns / 1ps

module tb_moving_average_filter;
  import mavg_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 17;
  localparam int RANDOM_ITEMS   = 1050;

  typedef struct {
    sample_t sample;
    logic    new_sig;
    int      gap;
  } sample_item_t;

  typedef struct {
    sample_t filtered;
    logic    warm;
  } avg_result_t;

  // DUT signals, all inputs driven to known values from time zero
  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                cfg_we   = 1'b0;
  logic [WIN_W-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata  = '0;   // [15:0] sample
  logic                s_tuser  = 1'b0; // [0] new_signal
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;         // [15:0] filtered
  logic                m_tuser;         // [0] warming_up

  // Filter model state
  sample_t           hist_ring [MAX_WINDOW] = '{default: '0};
  sum_t              hist_sum  = '0;
  int                hist_seen = 0;
  logic [PTR_W-1:0]  ring_ptr  = '0;
  int                win_len   = int'(WINDOW_RESET);

  // Stimulus and checking bookkeeping
  sample_item_t      pending_samples[$];
  avg_result_t       avg_expect[$];
  int                in_flight    = 0;
  int                mismatches   = 0;
  int                idle_cycles  = 0;
  int                random_sent  = 0;
  bit                tx_quiet     = 1'b0;
  bit                rx_quiet     = 1'b0;
  bit                in_taken     = 1'b0;
  bit                out_taken    = 1'b0;
  bit                tx_loaded    = 1'b0;
  bit                tx_v;
  int                tx_cnt       = 0;
  int                rx_cnt       = 0;
  sample_item_t      tx_cur;
  avg_result_t       got_exp;

  moving_average_filter u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // Model: window write clamps to 1..MAX_WINDOW and restarts the history
  task automatic apply_window(input logic [WIN_W-1:0] v);
    if (v == 0) begin
      win_len = 1;
    end else if (int'(v) > MAX_WINDOW) begin
      win_len = MAX_WINDOW;
    end else begin
      win_len = int'(v);
    end
    hist_sum  = '0;
    hist_seen = 0;
  endtask

  // Model: one sample in, one expected average (or raw warm-up sample) out
  function automatic void predict_average(input sample_t s, input logic new_sig);
    sample_t     oldest;
    int          count;
    avg_result_t r;
    if (new_sig) begin
      hist_sum  = '0;
      hist_seen = 0;
    end
    oldest = '0;
    if (hist_seen >= win_len) oldest = hist_ring[PTR_W'(int'(ring_ptr) - win_len)];
    hist_sum = hist_sum - oldest + s;
    hist_ring[ring_ptr] = s;
    ring_ptr = ring_ptr + 1'b1;
    count = hist_seen + 1;
    hist_seen = (count > MAX_WINDOW) ? MAX_WINDOW : count;
    if (count < win_len) begin
      r.filtered = s;
      r.warm     = 1'b1;
    end else begin
      r.filtered = sample_t'(int'(hist_sum) / win_len);
      r.warm     = 1'b0;
    end
    avg_expect.insert(avg_expect.size(), r);
  endfunction

  // Sample, check and predict at the rising edge
  always @(posedge clk) begin
    in_taken  <= !rst && s_tvalid && s_tready;
    out_taken <= !rst && m_tvalid && m_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (avg_expect.size() == 0) begin
          $error("unexpected result item: filtered %0d warming_up %0b",
                 $signed(m_tdata), m_tuser);
          mismatches++;
        end else begin
          got_exp = avg_expect.pop_front();
          if (m_tdata !== got_exp.filtered) begin
            $error("filtered: expected %0d, got %0d", got_exp.filtered, $signed(m_tdata));
            mismatches++;
          end
          if (m_tuser !== got_exp.warm) begin
            $error("warming_up: expected %0b, got %0b", got_exp.warm, m_tuser);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_average(sample_t'(s_tdata), s_tuser);
        in_flight--;
      end
      // Watchdog on cycles with no item moving on either side
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("moving_average_filter test failed");
          $finish;
        end
      end
    end
  end

  // Sample driver: pops pending items, waits each item's gap, holds until taken
  always @(negedge clk) begin
    if (!rst) begin
      tx_v = s_tvalid && !in_taken;
      if (!tx_v) begin
        if (!tx_loaded && pending_samples.size() > 0) begin
          tx_cur    = pending_samples.pop_front();
          tx_cnt    = tx_cur.gap;
          tx_loaded = 1'b1;
        end
        if (tx_loaded) begin
          if (tx_cnt == 0) begin
            tx_v      = 1'b1;
            tx_loaded = 1'b0;
            s_tdata  <= tx_cur.sample;
            s_tuser  <= tx_cur.new_sig;
          end else begin
            tx_cnt--;
          end
        end
      end
      s_tvalid <= tx_v;
    end
  end

  // Result sink: random stall after each taken item, none when rx_quiet is set
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) rx_cnt = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_cnt > 0) begin
        rx_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic queue_sample(input sample_t s, input logic new_sig);
    sample_item_t it;
    it.sample  = s;
    it.new_sig = new_sig;
    it.gap     = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    pending_samples.insert(pending_samples.size(), it);
    in_flight++;
  endtask

  // Hold off until every item went in and every result came back
  task automatic drain;
    while (in_flight != 0 || avg_expect.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    apply_window(v);
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin
    int      phase_len;
    int      pick;
    sample_t s;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Window 3 from reset: extremes, truncation toward zero, new signal
    queue_sample(16'sd32767, 1'b0);
    queue_sample(16'sd32767, 1'b0);
    queue_sample(16'sd32767, 1'b0);
    queue_sample(-16'sd32768, 1'b0);
    queue_sample(-16'sd32768, 1'b0);
    queue_sample(-16'sd32768, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(16'sd5, 1'b1);
    queue_sample(16'sd7, 1'b0);
    queue_sample(16'sd1, 1'b0);
    drain();

    // Zero window is taken as one: no warm-up, raw samples out
    write_window(WIN_W'(0));
    queue_sample(16'sd32767, 1'b0);
    queue_sample(-16'sd32768, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd100, 1'b1);
    drain();

    // Oversized window saturates to the deepest window
    write_window(WIN_W'(63));
    queue_sample(16'sd1, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd32767, 1'b0);
    queue_sample(-16'sd32768, 1'b1);
    drain();

    // Window 2: negative odd sum truncates toward zero
    write_window(WIN_W'(2));
    queue_sample(-16'sd32768, 1'b0);
    queue_sample(-16'sd32767, 1'b0);
    queue_sample(16'sd3, 1'b0);
    drain();

    // Random phases, each at its own window setting
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: begin
          write_window(WIN_W'(0));
        end
        1: begin
          write_window(WIN_W'(1));
        end
        2: begin
          write_window(WIN_W'(MAX_WINDOW));
        end
        3: begin
          write_window(WIN_W'($urandom_range(MAX_WINDOW + 1, 63)));
        end
        default: begin
          write_window(WIN_W'($urandom_range(2, MAX_WINDOW - 1)));
        end
      endcase
      tx_quiet  = ($urandom_range(0, 3) == 0);
      rx_quiet  = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 120);
      if (phase_len > RANDOM_ITEMS - random_sent) phase_len = RANDOM_ITEMS - random_sent;
      repeat (phase_len) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          s = 16'sd32767;
        end else if (pick == 1) begin
          s = -16'sd32768;
        end else begin
          s = sample_t'($urandom_range(0, 16'hFFFF));
        end
        queue_sample(s, $urandom_range(0, 39) == 0);
        random_sent++;
      end
      drain();
    end

    repeat (60) @(negedge clk);
    if (mismatches == 0 && avg_expect.size() == 0) begin
      $display("moving_average_filter test passed");
    end else begin
      $display("moving_average_filter test failed");
    end
    $finish;
  end

endmodule
